@@ sv/fsts_pkg.sv @@
// Shared constants, command type and airtime table of the flood slot time-sync core.
`timescale 1ns / 1ps
package fsts_pkg;

    // Averaging window and low/high tick ratio; both are powers of two
    localparam int SYNC_WINDOW = 16;
    localparam int TICK_RATIO  = 128;
    localparam longint CPU_HZ  = 4194304;
    localparam longint AIRTIME_DIV = 31250;

    localparam int SYNC_SHIFT = $clog2(SYNC_WINDOW);
    localparam int TICK_SHIFT = $clog2(TICK_RATIO);

    localparam int PKT_LEN_W   = 7;
    localparam int PKT_LEN_NUM = 2 ** PKT_LEN_W;
    localparam int AIRTIME_W   =
        $clog2(((longint'(PKT_LEN_NUM - 1) * CPU_HZ) / AIRTIME_DIV) + 1);
    localparam int OPND_W      = ((AIRTIME_W > 16) ? AIRTIME_W : 16) + 1;

    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_SESSION = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REFREQ  = 2'd2;

    typedef logic [AIRTIME_W-1:0] t_air_table [PKT_LEN_NUM];

    // Airtime in high-rate ticks for every packet length byte
    function automatic t_air_table f_air_table();
        t_air_table tbl;
        for (int i = 0; i < PKT_LEN_NUM; i++) begin
            tbl[i] = AIRTIME_W'((longint'(i) * CPU_HZ) / AIRTIME_DIV);
        end
        return tbl;
    endfunction

    localparam t_air_table AIRTIME_TABLE = f_air_table();

    typedef struct packed {
        logic load;
        logic smp_sum;
        logic smp_est;
        logic smp_acc;
        logic smp_win;
        logic ref_ops;
        logic ref_mul;
        logic ref_add;
        logic ref_fin;
        logic ref_clr;
        logic publish;
    } t_dp_cmd;

endpackage

@@ sv/fsts_ctrl.sv @@
// Sequencing state machine of the flood slot time-sync core.
`timescale 1ns / 1ps
module fsts_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [fsts_pkg::MODE_W-1:0]   i_mode,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output fsts_pkg::t_dp_cmd             o_cmd
);
    import fsts_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SUM  = 4'd1;
    localparam logic [3:0] ST_EST  = 4'd2;
    localparam logic [3:0] ST_ACC  = 4'd3;
    localparam logic [3:0] ST_WIN  = 4'd4;
    localparam logic [3:0] ST_OPS  = 4'd5;
    localparam logic [3:0] ST_MUL  = 4'd6;
    localparam logic [3:0] ST_ADD  = 4'd7;
    localparam logic [3:0] ST_REF  = 4'd8;
    localparam logic [3:0] ST_CLR  = 4'd9;
    localparam logic [3:0] ST_DONE = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    case (i_mode)
                        MODE_SESSION: n_state = ST_CLR;
                        MODE_SAMPLE:  n_state = ST_SUM;
                        MODE_REFREQ:  n_state = ST_OPS;
                        default:      n_state = ST_DONE;
                    endcase
                end
            end
            ST_SUM: begin
                o_cmd.smp_sum = 1'b1;
                n_state = ST_EST;
            end
            ST_EST: begin
                o_cmd.smp_est = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.smp_acc = 1'b1;
                n_state = ST_WIN;
            end
            ST_WIN: begin
                o_cmd.smp_win = 1'b1;
                n_state = ST_DONE;
            end
            ST_OPS: begin
                o_cmd.ref_ops = 1'b1;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.ref_mul = 1'b1;
                n_state = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.ref_add = 1'b1;
                n_state = ST_REF;
            end
            ST_REF: begin
                o_cmd.ref_fin = 1'b1;
                n_state = ST_DONE;
            end
            ST_CLR: begin
                o_cmd.ref_clr = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("input taken but controller did not leave idle");

    a_publish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |=> o_out_valid)
        else $error("result published but output not valid");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command in a cycle");

endmodule

@@ sv/fsts_datapath.sv @@
// Timestamp arithmetic, estimate averaging and reference registers of the time-sync core.
`timescale 1ns / 1ps
module fsts_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fsts_pkg::t_dp_cmd               i_cmd,
    input  logic                            i_cfg_we,
    input  logic [fsts_pkg::PKT_LEN_W-1:0]  i_cfg_data,
    input  logic [7:0]                      i_receive_count,
    input  logic [7:0]                      i_relay_count,
    input  logic [7:0]                      i_last_sent_relay,
    input  logic [15:0]                     i_rx_start_time,
    input  logic [15:0]                     i_prev_rx_stop_time,
    input  logic [15:0]                     i_tx_start_time,
    input  logic [15:0]                     i_tx_stop_time,
    input  logic [15:0]                     i_rx_stop_time,
    input  logic [15:0]                     i_capture_high,
    input  logic [15:0]                     i_capture_low,
    output logic [15:0]                     o_slot_estimate,
    output logic                            o_slot_updated,
    output logic [15:0]                     o_reference_low,
    output logic [6:0]                      o_reference_offset,
    output logic                            o_reference_valid
);
    import fsts_pkg::*;

    // Latched transfer fields
    logic [7:0]  r_rcv, r_relay, r_last;
    logic [15:0] r_rxs, r_prs, r_txs, r_txe, r_rxe, r_caph, r_capl;

    logic [AIRTIME_W-1:0] r_airtime;

    // Working registers
    logic [17:0]       r_sum;
    logic [15:0]       r_est;
    logic              r_smp_ok;
    logic              r_ref_ok;
    logic [OPND_W-1:0] r_opnd;
    logic [15:0]       r_cap_diff;
    logic [31:0]       r_prod;
    logic [31:0]       r_d;
    logic              r_updated;

    // Architectural state
    logic [15:0] r_slot_est;
    logic [31:0] r_slot_sum;
    logic [7:0]  r_window;
    logic [15:0] r_ref_low;
    logic [6:0]  r_ref_offset;
    logic        r_ref_done;

    // Published result
    logic [15:0] r_o_slot;
    logic        r_o_upd;
    logic [15:0] r_o_low;
    logic [6:0]  r_o_off;
    logic        r_o_valid;

    logic [15:0]           d0, d1, d2, d3;
    logic [31:0]           relay_m1;
    logic [TICK_SHIFT-1:0] d_frac;
    logic [TICK_SHIFT-1:0] off_full;

    assign d0 = r_txs - r_prs;
    assign d1 = r_txe - r_txs;
    assign d2 = r_rxs - r_txe;
    assign d3 = r_rxe - r_rxs;
    assign relay_m1 = {24'd0, r_relay} - 32'd1;
    assign d_frac   = r_d[TICK_SHIFT-1:0];
    assign off_full = TICK_SHIFT'(TICK_RATIO - 1) - d_frac;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rcv   <= i_receive_count;
            r_relay <= i_relay_count;
            r_last  <= i_last_sent_relay;
            r_rxs   <= i_rx_start_time;
            r_prs   <= i_prev_rx_stop_time;
            r_txs   <= i_tx_start_time;
            r_txe   <= i_tx_stop_time;
            r_rxe   <= i_rx_stop_time;
            r_caph  <= i_capture_high;
            r_capl  <= i_capture_low;
        end
        if (i_cmd.smp_sum) begin
            r_sum <= 18'(d0) + 18'(d1) + 18'(d2) + 18'(d3);
        end
        if (i_cmd.smp_est) begin
            r_est <= 16'(r_sum[17:1]) - 16'(r_airtime);
        end
        if (i_cmd.ref_ops) begin
            r_opnd     <= OPND_W'(r_slot_est) + OPND_W'(r_airtime);
            r_cap_diff <= r_caph - r_rxs;
        end
        if (i_cmd.ref_mul) begin
            r_prod <= 32'(relay_m1 * 32'(r_opnd));
        end
        if (i_cmd.ref_add) begin
            r_d <= r_prod + 32'(r_cap_diff);
        end
        if (i_cmd.publish) begin
            r_o_slot <= r_slot_est;
            r_o_upd  <= r_updated;
            r_o_low  <= r_ref_low;
            r_o_off  <= r_ref_offset;
            r_o_valid <= r_ref_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_airtime    <= '0;
            r_slot_est   <= '0;
            r_slot_sum   <= '0;
            r_window     <= '0;
            r_ref_low    <= '0;
            r_ref_offset <= '0;
            r_ref_done   <= 1'b0;
            r_updated    <= 1'b0;
            r_smp_ok     <= 1'b0;
            r_ref_ok     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_airtime <= AIRTIME_TABLE[i_cfg_data];
            end
            if (i_cmd.load) begin
                r_updated <= 1'b0;
            end
            if (i_cmd.smp_sum) begin
                r_smp_ok <= (r_rcv > 8'd1) &&
                            ({1'b0, r_relay} == ({1'b0, r_last} + 9'd2));
            end
            if (i_cmd.smp_acc && r_smp_ok) begin
                r_slot_sum <= r_slot_sum + 32'(r_est);
                r_window   <= r_window + 8'd1;
            end
            if (i_cmd.smp_win && r_smp_ok) begin
                if (r_window == 8'(SYNC_WINDOW)) begin
                    r_slot_est <= 16'(r_slot_sum >> SYNC_SHIFT);
                    r_slot_sum <= r_slot_sum >> 1;
                    r_window   <= r_window >> 1;
                    r_updated  <= 1'b1;
                end else if (r_window == 8'd1) begin
                    r_slot_est <= r_est;
                    r_updated  <= 1'b1;
                end
            end
            if (i_cmd.ref_ops) begin
                r_ref_ok <= (r_slot_est != 16'd0) && !r_ref_done;
            end
            if (i_cmd.ref_fin && r_ref_ok) begin
                r_ref_low    <= r_capl - 16'(32'd1 + (r_d >> TICK_SHIFT));
                r_ref_offset <= 7'(off_full);
                r_ref_done   <= 1'b1;
            end
            if (i_cmd.ref_clr) begin
                r_ref_done <= 1'b0;
            end
        end
    end

    assign o_slot_estimate    = r_o_slot;
    assign o_slot_updated     = r_o_upd;
    assign o_reference_low    = r_o_low;
    assign o_reference_offset = r_o_off;
    assign o_reference_valid  = r_o_valid;

    // The count reaches the full window in the accumulate step and is halved in the window step
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window <= 8'(SYNC_WINDOW))
        else $error("window count left its range");

    a_ref_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ref_done) |-> $past(i_cmd.ref_fin))
        else $error("reference set outside reference step");

    a_publish_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |=> (r_o_slot == $past(r_slot_est)) &&
                          (r_o_valid == $past(r_ref_done)))
        else $error("published result does not match state");

endmodule

@@ sv/flood_slot_time_sync.sv @@
// Top level of the flood slot time-sync core: controller plus datapath.
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake                 Payload
// in       into core  i_in_valid / o_in_stall   i_mode .. i_capture_low
// out      from core  o_out_valid / i_out_stall o_slot_estimate .. o_reference_valid
// cfg      into core  i_cfg_we                  i_cfg_data (packet length byte)
//
// One item at a time: the input stays stalled from each transfer until the
// controller has published its result and is back in idle.
// The sample path is sum, estimate, accumulate, window; the reference path is
// operand, multiply (32 x 17), add, reference - one register stage each.
// Reset (i_rst_n low, synchronous) clears all estimator and reference state.
// A finished result waits in the output register while the next item is
// transferred; if an older result still waits there, hold the controller in its
// last step and stall the input until the older result is transferred.
//
module flood_slot_time_sync (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_receive_count,
    input  logic [7:0]  i_relay_count,
    input  logic [7:0]  i_last_sent_relay,
    input  logic [15:0] i_rx_start_time,
    input  logic [15:0] i_prev_rx_stop_time,
    input  logic [15:0] i_tx_start_time,
    input  logic [15:0] i_tx_stop_time,
    input  logic [15:0] i_rx_stop_time,
    input  logic [15:0] i_capture_high,
    input  logic [15:0] i_capture_low,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_slot_estimate,
    output logic        o_slot_updated,
    output logic [15:0] o_reference_low,
    output logic [6:0]  o_reference_offset,
    output logic        o_reference_valid,
    // Configuration: packet length byte for the airtime term
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data
);
    import fsts_pkg::*;

    t_dp_cmd cmd;

    // Sequence the steps of each transfer
    fsts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Hold the fields, the estimator state and the result register
    fsts_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_receive_count     (i_receive_count),
        .i_relay_count       (i_relay_count),
        .i_last_sent_relay   (i_last_sent_relay),
        .i_rx_start_time     (i_rx_start_time),
        .i_prev_rx_stop_time (i_prev_rx_stop_time),
        .i_tx_start_time     (i_tx_start_time),
        .i_tx_stop_time      (i_tx_stop_time),
        .i_rx_stop_time      (i_rx_stop_time),
        .i_capture_high      (i_capture_high),
        .i_capture_low       (i_capture_low),
        .o_slot_estimate     (o_slot_estimate),
        .o_slot_updated      (o_slot_updated),
        .o_reference_low     (o_reference_low),
        .o_reference_offset  (o_reference_offset),
        .o_reference_valid   (o_reference_valid)
    );

endmodule
